FILE: hdl/mcat_pkg.sv
// Package for the minute clock alarm table.
// Holds opcodes, result kinds, time constants and the control and status types
// shared by the controller, the datapath and the top level. Depends on nothing.
package mcat_pkg;

	// Default table depth and the fixed result limit per tick.
	localparam int DEF_ALARM_SLOTS = 16;
	localparam int OUT_LIMIT       = 16;

	// Time of day constants.
	localparam int MINUTES_PER_HOUR = 60;
	localparam int HOURS_PER_DAY    = 24;
	localparam int SNOOZE_MINUTES   = 10;

	// Field widths fixed by the interface.
	localparam int OP_W     = 2;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int KIND_W   = 3;
	localparam int OSLOT_W  = 4;

	// Opcodes of an input transfer.
	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
	localparam logic [OP_W-1:0] OP_REPLY = 2'd2;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FIRED = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ADDED = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FULL  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REPLY = 3'd4;

	// One stored alarm entry.
	typedef struct packed {
		logic                snooz;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
	} slot_ent_t;

	// Source of the next result loaded into the output register.
	typedef enum logic [2:0] {
		OSEL_TICK,
		OSEL_FIRED,
		OSEL_ADDED,
		OSEL_FULL,
		OSEL_REPLY
	} out_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     accept;
		logic     tick;
		logic     rd_en;
		logic     rd_reply;
		logic     pend_take;
		logic     find_commit;
		logic     reply_commit;
		logic     load_out;
		out_sel_t out_sel;
		logic     out_last;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic match;
		logic slot_free;
		logic out_free;
	} sts_t;

endpackage

FILE: hdl/minute_clock_alarm_table.sv
// Top level of the minute clock alarm table.
// Instantiates the controller mcat_ctrl and the datapath mcat_dp; uses mcat_pkg.
module minute_clock_alarm_table
	import mcat_pkg::*;
#(
	parameter int ALARM_SLOTS = DEF_ALARM_SLOTS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     op,
	input  logic [HOUR_W-1:0]   new_hour,
	input  logic [MINUTE_W-1:0] new_minute,
	input  logic                new_snoozeable,
	input  logic [OSLOT_W-1:0]  reply_slot,
	input  logic                reply_snooze,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [KIND_W-1:0]   result_kind,
	output logic [OSLOT_W-1:0]  slot,
	output logic [HOUR_W-1:0]   set_hour,
	output logic [MINUTE_W-1:0] set_minute,
	output logic                is_snoozeable,
	output logic [HOUR_W-1:0]   now_hour_out,
	output logic [MINUTE_W-1:0] now_minute_out,
	output logic                last
);

	// The block keeps a time of day in hours and minutes, starting at 00:00
	// after reset, and a table of ALARM_SLOTS alarm entries (1 to 16). Each
	// input transfer carries an op: a minute tick advances the clock (wrapping
	// at 60 minutes and 24 hours) and then produces one fired result for every
	// valid entry that matches the new time, lowest slot first and at most 16,
	// or a single plain tick result when nothing matches. An add stores the
	// alarm in the lowest free slot, with hour and minute saturated to 23 and
	// 59, or reports that the table is full. A reply to a snoozeable alarm
	// either moves it ten minutes later or frees its slot; a reply to an empty,
	// repeatable or out of range slot changes nothing. An unknown op is
	// absorbed without a result. Every transfer's final result has last set.
	// The block handles one input transfer at a time and holds in_stall high
	// until its final result is in the output register. A tick reads the alarm
	// memory one slot per cycle, while the output side does not hold the scan,
	// through a single registered read port, and the decision on the last fired
	// result waits for the end of the scan. An add's free slot search steps
	// past each occupied slot in turn, and a reply does its memory read and
	// then its write back. The output register lets a new transfer be accepted
	// while the final result of the previous one still waits to be taken.
	// Valid bits clear at reset; the entry memory itself needs no clearing.

	localparam int SLOT_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

	cmd_t              cmd;
	sts_t              sts;
	logic [SLOT_W-1:0] idx;

	// Sequencing of scans, searches and replies.
	mcat_ctrl #(
		.ALARM_SLOTS(ALARM_SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.cmd      (cmd),
		.idx      (idx),
		.sts      (sts)
	);

	// Clock, alarm storage and the output register.
	mcat_dp #(
		.ALARM_SLOTS(ALARM_SLOTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.idx            (idx),
		.sts            (sts),
		.new_hour       (new_hour),
		.new_minute     (new_minute),
		.new_snoozeable (new_snoozeable),
		.reply_slot     (reply_slot),
		.reply_snooze   (reply_snooze),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.result_kind    (result_kind),
		.slot           (slot),
		.set_hour       (set_hour),
		.set_minute     (set_minute),
		.is_snoozeable  (is_snoozeable),
		.now_hour_out   (now_hour_out),
		.now_minute_out (now_minute_out),
		.last           (last)
	);

endmodule

FILE: hdl/mcat_dp.sv
// Datapath of the minute clock alarm table: clock registers, valid bits,
// alarm entry memory, pending fired result and the output register.
// Depends on mcat_pkg.
module mcat_dp
	import mcat_pkg::*;
#(
	parameter int ALARM_SLOTS = DEF_ALARM_SLOTS,
	localparam int SLOT_W     = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic [SLOT_W-1:0]   idx,
	output sts_t                sts,
	input  logic [HOUR_W-1:0]   new_hour,
	input  logic [MINUTE_W-1:0] new_minute,
	input  logic                new_snoozeable,
	input  logic [OSLOT_W-1:0]  reply_slot,
	input  logic                reply_snooze,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [KIND_W-1:0]   result_kind,
	output logic [OSLOT_W-1:0]  slot,
	output logic [HOUR_W-1:0]   set_hour,
	output logic [MINUTE_W-1:0] set_minute,
	output logic                is_snoozeable,
	output logic [HOUR_W-1:0]   now_hour_out,
	output logic [MINUTE_W-1:0] now_minute_out,
	output logic                last
);

	// Clock and table state.
	logic [HOUR_W-1:0]   now_hour_q;
	logic [MINUTE_W-1:0] now_minute_q;
	logic [ALARM_SLOTS-1:0] valid_q;
	slot_ent_t           mem [ALARM_SLOTS];

	// Latched request fields.
	slot_ent_t           in_ent_q;
	logic [OSLOT_W-1:0]  rs_q;
	logic                rs_ok_q;
	logic                rz_q;

	// Memory read stage and pending fired result.
	slot_ent_t           rd_data_q;
	logic [SLOT_W-1:0]   slot_s1;
	slot_ent_t           pend_ent_q;
	logic [SLOT_W-1:0]   pend_slot_q;

	// Output register.
	logic                out_valid_q;
	logic [KIND_W-1:0]   kind_q;
	logic [OSLOT_W-1:0]  slot_q;
	logic [HOUR_W-1:0]   set_hour_q;
	logic [MINUTE_W-1:0] set_minute_q;
	logic                snooz_q;
	logic [HOUR_W-1:0]   now_hour_o_q;
	logic [MINUTE_W-1:0] now_minute_o_q;
	logic                last_q;

	logic [SLOT_W+OSLOT_W-1:0] rs_ext;
	logic [SLOT_W-1:0]   rs_idx;
	logic [SLOT_W-1:0]   rd_addr;
	logic [SLOT_W-1:0]   wr_addr;
	slot_ent_t           wr_data;
	logic                wr_en;
	logic                rep_ok;
	logic [MINUTE_W:0]   snz_min_sum;
	logic [MINUTE_W-1:0] snz_minute;
	logic [HOUR_W-1:0]   snz_hour;
	logic [SLOT_W+OSLOT_W-1:0] pend_slot_ext;
	logic [SLOT_W+OSLOT_W-1:0] idx_ext;
	logic [HOUR_W-1:0]   sat_hour;
	logic [MINUTE_W-1:0] sat_minute;

	assign rs_ext  = {{SLOT_W{1'b0}}, rs_q};
	assign rs_idx  = rs_ext[SLOT_W-1:0];
	assign rd_addr = cmd.rd_reply ? rs_idx : idx;

	assign sat_hour   = (new_hour > HOUR_W'(HOURS_PER_DAY - 1)) ?
		HOUR_W'(HOURS_PER_DAY - 1) : new_hour;
	assign sat_minute = (new_minute > MINUTE_W'(MINUTES_PER_HOUR - 1)) ?
		MINUTE_W'(MINUTES_PER_HOUR - 1) : new_minute;

	// Snooze moves the alarm ten minutes later, carrying into the hour.
	always_comb begin
		snz_min_sum = {1'b0, rd_data_q.minute} + (MINUTE_W+1)'(SNOOZE_MINUTES);
		snz_minute  = snz_min_sum[MINUTE_W-1:0];
		snz_hour    = rd_data_q.hour;
		if (snz_min_sum >= (MINUTE_W+1)'(MINUTES_PER_HOUR)) begin
			snz_minute = MINUTE_W'(snz_min_sum - (MINUTE_W+1)'(MINUTES_PER_HOUR));
			if (rd_data_q.hour == HOUR_W'(HOURS_PER_DAY - 1)) begin
				snz_hour = '0;
			end else begin
				snz_hour = rd_data_q.hour + HOUR_W'(1);
			end
		end
	end

	assign rep_ok = rs_ok_q && valid_q[rs_idx] && rd_data_q.snooz;

	// Single write port shared by add and snooze.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx;
		wr_data = in_ent_q;
		if (cmd.find_commit) begin
			wr_en = 1'b1;
		end else if (cmd.reply_commit && rep_ok && rz_q) begin
			wr_en   = 1'b1;
			wr_addr = rs_idx;
			wr_data = '{snooz: rd_data_q.snooz, hour: snz_hour, minute: snz_minute};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
			slot_s1   <= rd_addr;
		end
	end

	assign sts.match = valid_q[slot_s1] && (rd_data_q.hour == now_hour_q) &&
		(rd_data_q.minute == now_minute_q);
	assign sts.slot_free = !valid_q[idx];
	assign sts.out_free  = !out_valid_q || !out_stall;

	// Clock and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_hour_q   <= '0;
			now_minute_q <= '0;
			valid_q      <= '0;
		end else begin
			if (cmd.tick) begin
				if (now_minute_q == MINUTE_W'(MINUTES_PER_HOUR - 1)) begin
					now_minute_q <= '0;
					if (now_hour_q == HOUR_W'(HOURS_PER_DAY - 1)) begin
						now_hour_q <= '0;
					end else begin
						now_hour_q <= now_hour_q + HOUR_W'(1);
					end
				end else begin
					now_minute_q <= now_minute_q + MINUTE_W'(1);
				end
			end
			if (cmd.find_commit) begin
				valid_q[idx] <= 1'b1;
			end
			if (cmd.reply_commit && rep_ok && !rz_q) begin
				valid_q[rs_idx] <= 1'b0;
			end
		end
	end

	// Request fields and pending fired result.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			in_ent_q <= '{snooz: new_snoozeable, hour: sat_hour, minute: sat_minute};
			rs_q     <= reply_slot;
			rs_ok_q  <= ({3'b000, reply_slot} < 7'(ALARM_SLOTS));
			rz_q     <= reply_snooze;
		end
		if (cmd.pend_take) begin
			pend_ent_q  <= rd_data_q;
			pend_slot_q <= slot_s1;
		end
	end

	assign pend_slot_ext = {{OSLOT_W{1'b0}}, pend_slot_q};
	assign idx_ext       = {{OSLOT_W{1'b0}}, idx};

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			now_hour_o_q   <= now_hour_q;
			now_minute_o_q <= now_minute_q;
			last_q         <= cmd.out_last;
			unique case (cmd.out_sel)
				OSEL_FIRED: begin
					kind_q       <= KIND_FIRED;
					slot_q       <= pend_slot_ext[OSLOT_W-1:0];
					set_hour_q   <= pend_ent_q.hour;
					set_minute_q <= pend_ent_q.minute;
					snooz_q      <= pend_ent_q.snooz;
				end
				OSEL_ADDED: begin
					kind_q       <= KIND_ADDED;
					slot_q       <= idx_ext[OSLOT_W-1:0];
					set_hour_q   <= in_ent_q.hour;
					set_minute_q <= in_ent_q.minute;
					snooz_q      <= in_ent_q.snooz;
				end
				OSEL_FULL: begin
					kind_q       <= KIND_FULL;
					slot_q       <= '0;
					set_hour_q   <= '0;
					set_minute_q <= '0;
					snooz_q      <= 1'b0;
				end
				OSEL_REPLY: begin
					kind_q  <= KIND_REPLY;
					slot_q  <= rs_q;
					snooz_q <= 1'b0;
					if (!rep_ok) begin
						set_hour_q   <= '0;
						set_minute_q <= '0;
					end else if (rz_q) begin
						set_hour_q   <= snz_hour;
						set_minute_q <= snz_minute;
					end else begin
						set_hour_q   <= rd_data_q.hour;
						set_minute_q <= rd_data_q.minute;
					end
				end
				default: begin
					kind_q       <= KIND_TICK;
					slot_q       <= '0;
					set_hour_q   <= '0;
					set_minute_q <= '0;
					snooz_q      <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = kind_q;
	assign slot           = slot_q;
	assign set_hour       = set_hour_q;
	assign set_minute     = set_minute_q;
	assign is_snoozeable  = snooz_q;
	assign now_hour_out   = now_hour_o_q;
	assign now_minute_out = now_minute_o_q;
	assign last           = last_q;

endmodule

FILE: hdl/mcat_ctrl.sv
// Controller of the minute clock alarm table: sequences the slot scan of a
// tick, the free slot search of an add and the read and write back of a reply.
// Depends on mcat_pkg.
module mcat_ctrl
	import mcat_pkg::*;
#(
	parameter int ALARM_SLOTS = DEF_ALARM_SLOTS,
	localparam int SLOT_W     = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [OP_W-1:0]   op,
	output cmd_t              cmd,
	output logic [SLOT_W-1:0] idx,
	input  sts_t              sts
);

	localparam int CNT_W = $clog2(ALARM_SLOTS + 1);
	localparam int FND_W = $clog2(OUT_LIMIT + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_FLUSH = 3'd2;
	localparam logic [2:0] ST_FIND  = 3'd3;
	localparam logic [2:0] ST_RRD   = 3'd4;
	localparam logic [2:0] ST_RWB   = 3'd5;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [FND_W-1:0] found_q, found_d;
	logic             pend_live_q, pend_live_d;
	logic             live_s1, live_d;
	logic             match_now;
	logic             hold;
	logic             issue;
	logic             at_end;

	assign idx       = cnt_q[SLOT_W-1:0];
	assign in_stall  = (state_q != ST_IDLE);
	assign match_now = live_s1 && sts.match;
	assign hold      = match_now && pend_live_q && !sts.out_free;
	assign at_end    = (cnt_q == CNT_W'(ALARM_SLOTS));

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		found_d     = found_q;
		pend_live_d = pend_live_q;
		live_d      = live_s1;
		issue       = 1'b0;
		cmd         = '{out_sel: OSEL_TICK, out_last: 1'b1, default: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					cnt_d      = '0;
					unique case (op)
						OP_TICK: begin
							cmd.tick    = 1'b1;
							found_d     = '0;
							pend_live_d = 1'b0;
							live_d      = 1'b0;
							state_d     = ST_SCAN;
						end
						OP_ADD:   state_d = ST_FIND;
						OP_REPLY: state_d = ST_RRD;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (!hold) begin
					// A new match becomes pending; the older one goes out.
					if (match_now) begin
						cmd.pend_take = 1'b1;
						pend_live_d   = 1'b1;
						found_d       = found_q + FND_W'(1);
						if (pend_live_q) begin
							cmd.load_out = 1'b1;
							cmd.out_sel  = OSEL_FIRED;
							cmd.out_last = 1'b0;
						end
					end
					issue = !at_end && (found_d < FND_W'(OUT_LIMIT));
					live_d = issue;
					if (issue) begin
						cmd.rd_en = 1'b1;
						cnt_d     = cnt_q + CNT_W'(1);
					end else begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = pend_live_q ? OSEL_FIRED : OSEL_TICK;
					state_d      = ST_IDLE;
				end
			end
			ST_FIND: begin
				if (at_end) begin
					if (sts.out_free) begin
						cmd.load_out = 1'b1;
						cmd.out_sel  = OSEL_FULL;
						state_d      = ST_IDLE;
					end
				end else if (sts.slot_free) begin
					if (sts.out_free) begin
						cmd.find_commit = 1'b1;
						cmd.load_out    = 1'b1;
						cmd.out_sel     = OSEL_ADDED;
						state_d         = ST_IDLE;
					end
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			ST_RRD: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_reply = 1'b1;
				state_d      = ST_RWB;
			end
			ST_RWB: begin
				if (sts.out_free) begin
					cmd.reply_commit = 1'b1;
					cmd.load_out     = 1'b1;
					cmd.out_sel      = OSEL_REPLY;
					state_d          = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			found_q     <= '0;
			pend_live_q <= 1'b0;
			live_s1     <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			found_q     <= found_d;
			pend_live_q <= pend_live_d;
			live_s1     <= live_d;
		end
	end

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for minute_clock_alarm_table.
// Runs a directed table and then random transfers against a local predictor of the
// clock and alarm table. Depends only on mcat_pkg and the RTL of the block.
module testbench;
	import mcat_pkg::*;

	localparam int SLOTS          = DEF_ALARM_SLOTS;
	localparam int RANDOM_ITEMS   = 140;
	// The final stretch of random transfers runs with no gaps and no stalls.
	localparam int STEADY_ITEMS   = 30;
	localparam int DRAIN_CYCLES   = 60;
	localparam int CYCLE_LIMIT    = 600000;
	localparam int MAX_REPORTS    = 50;
	localparam int MINUTES_PER_DAY = MINUTES_PER_HOUR * HOURS_PER_DAY;

	// The block has no meaning for op code 3 and drops such transfers silently.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// One input transfer, field for field as on the ports.
	typedef struct packed {
		logic [OP_W-1:0]     code;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic                snz;
		logic [OSLOT_W-1:0]  rslot;
		logic                rz;
	} alarm_cmd_t;

	// One result transfer, field for field as on the ports.
	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [OSLOT_W-1:0]  slot;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic                snz;
		logic [HOUR_W-1:0]   now_h;
		logic [MINUTE_W-1:0] now_m;
		logic                last;
	} alarm_result_t;

	// A row of the directed table. The command is sent count times in a row. When
	// typed is set, the single result is the one written in the row; otherwise
	// the predictor supplies the results.
	typedef struct packed {
		alarm_cmd_t    cmd;
		logic [11:0]   count;
		logic          typed;
		alarm_result_t want;
	} plan_row_t;

	localparam alarm_result_t NO_TYPED = '0;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [OP_W-1:0]     op;
	logic [HOUR_W-1:0]   new_hour;
	logic [MINUTE_W-1:0] new_minute;
	logic                new_snoozeable;
	logic [OSLOT_W-1:0]  reply_slot;
	logic                reply_snooze;
	logic                out_valid;
	logic                out_stall;
	logic [KIND_W-1:0]   result_kind;
	logic [OSLOT_W-1:0]  slot;
	logic [HOUR_W-1:0]   set_hour;
	logic [MINUTE_W-1:0] set_minute;
	logic                is_snoozeable;
	logic [HOUR_W-1:0]   now_hour_out;
	logic [MINUTE_W-1:0] now_minute_out;
	logic                last;

	minute_clock_alarm_table #(
		.ALARM_SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.new_hour(new_hour),
		.new_minute(new_minute),
		.new_snoozeable(new_snoozeable),
		.reply_slot(reply_slot),
		.reply_snooze(reply_snooze),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.slot(slot),
		.set_hour(set_hour),
		.set_minute(set_minute),
		.is_snoozeable(is_snoozeable),
		.now_hour_out(now_hour_out),
		.now_minute_out(now_minute_out),
		.last(last)
	);

	// Predictor state: the time of day and the alarm table as the block should hold
	// them after every accepted transfer.
	logic [HOUR_W-1:0]   clock_hour;
	logic [MINUTE_W-1:0] clock_minute;
	logic                alarm_valid  [SLOTS];
	logic [HOUR_W-1:0]   alarm_hour   [SLOTS];
	logic [MINUTE_W-1:0] alarm_minute [SLOTS];
	logic                alarm_snz    [SLOTS];

	alarm_result_t step_results[$];
	alarm_result_t pending_results[$];

	int mismatch_count = 0;
	int cycle_count = 0;
	bit gaps_on = 1'b1;

	// Directed table. The clock starts at 00:00 after reset. It exercises the
	// saturation of an out-of-range add, two alarms firing on one tick, replies to
	// a repeatable and to an empty slot, snooze and remove, filling the table until
	// an add is refused, ticks across the minute wrap into the next hour with
	// thirteen alarms firing at once, and snoozes that carry into the hour and
	// across midnight.
	plan_row_t directed_plan [0:19] = '{
		'{'{OP_TICK,   5'd0,  6'd0,  1'b0, 4'd0, 1'b0}, 12'd1,    1'b1,
			'{KIND_TICK,  4'd0, 5'd0,  6'd0,  1'b0, 5'd0, 6'd1, 1'b1}},
		'{'{OP_UNUSED, 5'd31, 6'd63, 1'b1, 4'd15, 1'b1}, 12'd1,   1'b0, NO_TYPED},
		'{'{OP_ADD,    5'd31, 6'd63, 1'b1, 4'd0, 1'b0}, 12'd1,    1'b1,
			'{KIND_ADDED, 4'd0, 5'd23, 6'd59, 1'b1, 5'd0, 6'd1, 1'b1}},
		'{'{OP_ADD,    5'd0,  6'd2,  1'b0, 4'd0, 1'b0}, 12'd1,    1'b1,
			'{KIND_ADDED, 4'd1, 5'd0,  6'd2,  1'b0, 5'd0, 6'd1, 1'b1}},
		'{'{OP_ADD,    5'd0,  6'd2,  1'b1, 4'd0, 1'b0}, 12'd1,    1'b1,
			'{KIND_ADDED, 4'd2, 5'd0,  6'd2,  1'b1, 5'd0, 6'd1, 1'b1}},
		'{'{OP_TICK,   5'd0,  6'd0,  1'b0, 4'd0, 1'b0}, 12'd1,    1'b0, NO_TYPED},
		'{'{OP_REPLY,  5'd0,  6'd0,  1'b0, 4'd1, 1'b1}, 12'd1,    1'b1,
			'{KIND_REPLY, 4'd1, 5'd0,  6'd0,  1'b0, 5'd0, 6'd2, 1'b1}},
		'{'{OP_REPLY,  5'd0,  6'd0,  1'b0, 4'd9, 1'b0}, 12'd1,    1'b1,
			'{KIND_REPLY, 4'd9, 5'd0,  6'd0,  1'b0, 5'd0, 6'd2, 1'b1}},
		'{'{OP_REPLY,  5'd0,  6'd0,  1'b0, 4'd2, 1'b1}, 12'd1,    1'b1,
			'{KIND_REPLY, 4'd2, 5'd0,  6'd12, 1'b0, 5'd0, 6'd2, 1'b1}},
		'{'{OP_REPLY,  5'd0,  6'd0,  1'b0, 4'd2, 1'b0}, 12'd1,    1'b1,
			'{KIND_REPLY, 4'd2, 5'd0,  6'd12, 1'b0, 5'd0, 6'd2, 1'b1}},
		'{'{OP_ADD,    5'd0,  6'd0,  1'b0, 4'd0, 1'b0}, 12'd1,    1'b1,
			'{KIND_ADDED, 4'd2, 5'd0,  6'd0,  1'b0, 5'd0, 6'd2, 1'b1}},
		'{'{OP_ADD,    5'd1,  6'd0,  1'b1, 4'd0, 1'b0}, 12'd13,   1'b0, NO_TYPED},
		'{'{OP_ADD,    5'd5,  6'd5,  1'b1, 4'd0, 1'b0}, 12'd1,    1'b1,
			'{KIND_FULL,  4'd0, 5'd0,  6'd0,  1'b0, 5'd0, 6'd2, 1'b1}},
		'{'{OP_TICK,   5'd0,  6'd0,  1'b0, 4'd0, 1'b0}, 12'd58,   1'b0, NO_TYPED},
		'{'{OP_REPLY,  5'd0,  6'd0,  1'b0, 4'd0, 1'b1}, 12'd1,    1'b1,
			'{KIND_REPLY, 4'd0, 5'd0,  6'd9,  1'b0, 5'd1, 6'd0, 1'b1}},
		'{'{OP_REPLY,  5'd0,  6'd0,  1'b0, 4'd0, 1'b1}, 12'd1,    1'b0, NO_TYPED},
		'{'{OP_REPLY,  5'd0,  6'd0,  1'b0, 4'd3, 1'b0}, 12'd1,    1'b1,
			'{KIND_REPLY, 4'd3, 5'd1,  6'd0,  1'b0, 5'd1, 6'd0, 1'b1}},
		'{'{OP_ADD,    5'd12, 6'd55, 1'b1, 4'd0, 1'b0}, 12'd1,    1'b0, NO_TYPED},
		'{'{OP_REPLY,  5'd0,  6'd0,  1'b0, 4'd3, 1'b1}, 12'd1,    1'b1,
			'{KIND_REPLY, 4'd3, 5'd13, 6'd5,  1'b0, 5'd1, 6'd0, 1'b1}},
		'{'{OP_REPLY,  5'd0,  6'd0,  1'b0, 4'd4, 1'b1}, 12'd1,    1'b0, NO_TYPED}
	};

	// Clock generator: period of 10 time units.
	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// Watchdog. A hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Prints one line per mismatch, up to a cap, and counts every one of them.
	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("cycle %0d: %s", cycle_count, msg);
		end
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want) begin
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
		end
	endtask

	// Appends one result to the results of the current step.
	task automatic queue_step(input alarm_result_t r);
		step_results = {step_results, r};
	endtask

	// Builds a result stamped with the current predicted time of day.
	function automatic alarm_result_t stamp_result(input logic [KIND_W-1:0] kind,
		input int idx, input int hour, input int minute, input logic snz);
		alarm_result_t r;
		r.kind   = kind;
		r.slot   = OSLOT_W'(idx);
		r.hour   = HOUR_W'(hour);
		r.minute = MINUTE_W'(minute);
		r.snz    = snz;
		r.now_h  = clock_hour;
		r.now_m  = clock_minute;
		r.last   = 1'b0;
		return r;
	endfunction

	// Advances the predicted clock and table by one accepted transfer and leaves the
	// results that the transfer must produce in step_results.
	task automatic predict_alarm_step(input alarm_cmd_t c);
		int h;
		int m;
		int free_slot;
		step_results.delete();
		case (c.code)
			OP_TICK: begin
				h = clock_hour;
				m = clock_minute + 1;
				if (m >= MINUTES_PER_HOUR) begin
					m = 0;
					h++;
				end
				if (h >= HOURS_PER_DAY) begin
					h = 0;
					m = 0;
				end
				clock_hour   = HOUR_W'(h);
				clock_minute = MINUTE_W'(m);
				// Every matching slot fires, lowest first, up to the per-tick limit.
				for (int i = 0; i < SLOTS; i++) begin
					if (step_results.size() < OUT_LIMIT && alarm_valid[i] &&
						alarm_hour[i] == clock_hour && alarm_minute[i] == clock_minute) begin
						queue_step(stamp_result(KIND_FIRED, i, alarm_hour[i],
							alarm_minute[i], alarm_snz[i]));
					end
				end
				if (step_results.size() == 0) begin
					queue_step(stamp_result(KIND_TICK, 0, 0, 0, 1'b0));
				end
			end
			OP_ADD: begin
				// Out-of-range times are clamped to the last hour and minute.
				h = (c.hour > HOURS_PER_DAY - 1) ? HOURS_PER_DAY - 1 : int'(c.hour);
				m = (c.minute > MINUTES_PER_HOUR - 1) ? MINUTES_PER_HOUR - 1 : int'(c.minute);
				free_slot = -1;
				for (int i = 0; i < SLOTS; i++) begin
					if (free_slot < 0 && !alarm_valid[i]) begin
						free_slot = i;
					end
				end
				if (free_slot < 0) begin
					queue_step(stamp_result(KIND_FULL, 0, 0, 0, 1'b0));
				end else begin
					alarm_valid[free_slot]  = 1'b1;
					alarm_hour[free_slot]   = HOUR_W'(h);
					alarm_minute[free_slot] = MINUTE_W'(m);
					alarm_snz[free_slot]    = c.snz;
					queue_step(stamp_result(KIND_ADDED, free_slot, h, m, c.snz));
				end
			end
			OP_REPLY: begin
				// Only a valid snoozeable alarm reacts; anything else is answered
				// with a bare reply result.
				if (int'(c.rslot) < SLOTS && alarm_valid[c.rslot] && alarm_snz[c.rslot]) begin
					if (c.rz) begin
						m = alarm_minute[c.rslot] + SNOOZE_MINUTES;
						h = alarm_hour[c.rslot];
						if (m >= MINUTES_PER_HOUR) begin
							m -= MINUTES_PER_HOUR;
							h++;
							if (h >= HOURS_PER_DAY) begin
								h = 0;
							end
						end
						alarm_hour[c.rslot]   = HOUR_W'(h);
						alarm_minute[c.rslot] = MINUTE_W'(m);
					end else begin
						alarm_valid[c.rslot] = 1'b0;
					end
					queue_step(stamp_result(KIND_REPLY, c.rslot,
						alarm_hour[c.rslot], alarm_minute[c.rslot], 1'b0));
				end else begin
					queue_step(stamp_result(KIND_REPLY, c.rslot, 0, 0, 1'b0));
				end
			end
			default: begin
				// Unused op code: no state change and no result.
			end
		endcase
		if (step_results.size() > 0) begin
			step_results[step_results.size() - 1].last = 1'b1;
		end
	endtask

	// Presents one command and returns at the clock edge where it was taken. An idle
	// gap may come first while gaps are enabled. The payload is held steady for as
	// long as the block stalls.
	task automatic send_alarm_cmd(input alarm_cmd_t c);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		op             <= c.code;
		new_hour       <= c.hour;
		new_minute     <= c.minute;
		new_snoozeable <= c.snz;
		reply_slot     <= c.rslot;
		reply_snooze   <= c.rz;
		do begin
			@(posedge clk);
		end while (in_stall);
	endtask

	// Random command. Most adds land a few minutes ahead of the clock so that ticks
	// soon fire them, and most replies go to slots that hold an alarm. Fields that
	// the op does not use still carry noise.
	function automatic alarm_cmd_t random_alarm_cmd();
		alarm_cmd_t c;
		int pick;
		int t;
		int live[$];
		c.code   = OP_W'($urandom_range(0, 3));
		c.hour   = HOUR_W'($urandom_range(0, 31));
		c.minute = MINUTE_W'($urandom_range(0, 63));
		c.snz    = 1'($urandom_range(0, 1));
		c.rslot  = OSLOT_W'($urandom_range(0, 15));
		c.rz     = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			c.code = OP_UNUSED;
		end else if (pick < 45) begin
			c.code = OP_TICK;
		end else if (pick < 72) begin
			c.code = OP_ADD;
			if ($urandom_range(0, 2) != 0) begin
				t = (clock_hour * MINUTES_PER_HOUR + clock_minute + $urandom_range(1, 4)) %
					MINUTES_PER_DAY;
				c.hour   = HOUR_W'(t / MINUTES_PER_HOUR);
				c.minute = MINUTE_W'(t % MINUTES_PER_HOUR);
			end
		end else begin
			c.code = OP_REPLY;
			for (int i = 0; i < SLOTS; i++) begin
				if (alarm_valid[i]) begin
					live = {live, i};
				end
			end
			if (live.size() > 0 && $urandom_range(0, 3) != 0) begin
				c.rslot = OSLOT_W'(live[$urandom_range(0, live.size() - 1)]);
			end
		end
		return c;
	endfunction

	// Result side: checks every result transfer against the oldest expectation and
	// stalls the block in random bursts.
	initial begin : result_side
		int burst;
		alarm_result_t got;
		alarm_result_t want;
		burst = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got = '{result_kind, slot, set_hour, set_minute, is_snoozeable,
					now_hour_out, now_minute_out, last};
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result transfer, kind %0d slot %0d",
						got.kind, got.slot));
				end else begin
					want = pending_results.pop_front();
					check_field("result_kind", got.kind, want.kind);
					check_field("slot", got.slot, want.slot);
					check_field("set_hour", got.hour, want.hour);
					check_field("set_minute", got.minute, want.minute);
					check_field("is_snoozeable", got.snz, want.snz);
					check_field("now_hour_out", got.now_h, want.now_h);
					check_field("now_minute_out", got.now_m, want.now_m);
					check_field("last", got.last, want.last);
				end
			end
			if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if (gaps_on && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Command side: reset, the directed table, the random part, then the drain.
	initial begin : command_side
		alarm_cmd_t c;
		int counted;
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		op             <= OP_TICK;
		new_hour       <= '0;
		new_minute     <= '0;
		new_snoozeable <= 1'b0;
		reply_slot     <= '0;
		reply_snooze   <= 1'b0;
		clock_hour   = '0;
		clock_minute = '0;
		for (int i = 0; i < SLOTS; i++) begin
			alarm_valid[i]  = 1'b0;
			alarm_hour[i]   = '0;
			alarm_minute[i] = '0;
			alarm_snz[i]    = 1'b0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Typed rows queue the expectation written in the table; the predictor
		// still runs so that its state follows the block.
		foreach (directed_plan[r]) begin
			for (int n = 0; n < int'(directed_plan[r].count); n++) begin
				send_alarm_cmd(directed_plan[r].cmd);
				predict_alarm_step(directed_plan[r].cmd);
				if (directed_plan[r].typed) begin
					pending_results = {pending_results, directed_plan[r].want};
				end else begin
					pending_results = {pending_results, step_results};
				end
			end
		end

		// Ignored transfers do not count toward the random total.
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if (counted >= RANDOM_ITEMS - STEADY_ITEMS) begin
				gaps_on = 1'b0;
			end
			c = random_alarm_cmd();
			send_alarm_cmd(c);
			predict_alarm_step(c);
			pending_results = {pending_results, step_results};
			if (c.code != OP_UNUSED) begin
				counted++;
			end
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
